// ----- rtl/two_level_inclusive_cache_srrip_unit_defines.svh -----
// Assertion macros for the two-level inclusive cache unit
`ifndef TWO_LEVEL_INCLUSIVE_CACHE_SRRIP_UNIT_DEFINES_SVH
`define TWO_LEVEL_INCLUSIVE_CACHE_SRRIP_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TLC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`define TLC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TLC_ASSERT_NEVER(lbl, clk, rst, expr)
`define TLC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/tlc_pkg.sv -----
// Shared constants and control types for the two-level inclusive cache unit
package tlc_pkg;
   localparam int ADDR_W      = 48;
   localparam int SIZE_W      = 7;
   localparam int BLK_W       = 42;
   localparam int CNT_W       = 48;
   localparam int BLOCK_SHIFT = 6;
   localparam int BLOCK_BYTES = 64;
   localparam logic [1:0] RRPV_MAX  = 2'd3;
   localparam logic [1:0] RRPV_FILL = 2'd2;
   localparam logic [1:0] RRPV_HIT  = 2'd0;

   localparam int DEF_L1_SETS    = 128;
   localparam int DEF_L1_WAYS    = 8;
   localparam int DEF_L2_SETS    = 1024;
   localparam int DEF_L2_WAYS    = 16;
   localparam int DEF_ADDR_WIDTH = 48;

   typedef struct packed {
      logic load;
      logic rd_cur;
      logic lookup;
      logic bi_rd;
      logic bi_wr;
      logic rd_l1;
      logic fill;
      logic next_blk;
      logic clr;
   } tlc_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic need_bi;
      logic last;
   } tlc_sts_type;
endpackage

// ----- rtl/two_level_inclusive_cache_srrip_unit.sv -----
// Top level: two-level inclusive tag cache with LRU L1 and SRRIP L2
// Each block is read, looked up and shown; when an L2 victim needs an L1 back-invalidate,
// the victim's L1 set is read and rewritten and the current L1 set reread and filled first.
// A second block is handled after the first result is taken. One item at a time: no new
// request is taken until its last result is taken, and output stalls hold the flow.
// Reset: counters clear, then a valid-clear sweep of max(L1_SETS, L2_SETS) sets.
module two_level_inclusive_cache_srrip_unit #(
   parameter int L1_SETS    = tlc_pkg::DEF_L1_SETS,
   parameter int L1_WAYS    = tlc_pkg::DEF_L1_WAYS,
   parameter int L2_SETS    = tlc_pkg::DEF_L2_SETS,
   parameter int L2_WAYS    = tlc_pkg::DEF_L2_WAYS,
   parameter int ADDR_WIDTH = tlc_pkg::DEF_ADDR_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [tlc_pkg::ADDR_W-1:0] req_start_address,
   input  logic [tlc_pkg::SIZE_W-1:0] req_access_size,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [tlc_pkg::BLK_W-1:0]  rsp_block_address,
   output logic                       rsp_l1_hit,
   output logic                       rsp_l2_hit,
   output logic                       rsp_last_block,
   output logic [tlc_pkg::CNT_W-1:0]  rsp_l1_miss_total,
   output logic [tlc_pkg::CNT_W-1:0]  rsp_l2_miss_total
);
   import tlc_pkg::*;

   tlc_cmd_type cmd;
   tlc_sts_type sts;

   tlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlc_dp #(
      .L1_SETS    (L1_SETS),
      .L1_WAYS    (L1_WAYS),
      .L2_SETS    (L2_SETS),
      .L2_WAYS    (L2_WAYS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_start_address (req_start_address),
      .req_access_size   (req_access_size),
      .rsp_block_address (rsp_block_address),
      .rsp_l1_hit        (rsp_l1_hit),
      .rsp_l2_hit        (rsp_l2_hit),
      .rsp_last_block    (rsp_last_block),
      .rsp_l1_miss_total (rsp_l1_miss_total),
      .rsp_l2_miss_total (rsp_l2_miss_total)
   );
endmodule

// ----- rtl/tlc_ctrl.sv -----
// Sequencing state machine for the two-level inclusive cache unit
module tlc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tlc_pkg::tlc_sts_type sts,
   output tlc_pkg::tlc_cmd_type cmd
);
   import tlc_pkg::*;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_LK   = 4'd3;
   localparam logic [3:0] S_BIR  = 4'd4;
   localparam logic [3:0] S_BIW  = 4'd5;
   localparam logic [3:0] S_L1R  = 4'd6;
   localparam logic [3:0] S_FILL = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLR: begin
            cmd.clr = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_LK;
         end
         S_LK: begin
            cmd.lookup = 1'b1;
            state_in   = sts.need_bi ? S_BIR : S_OUT;
         end
         S_BIR: begin
            cmd.bi_rd = 1'b1;
            state_in  = S_BIW;
         end
         S_BIW: begin
            cmd.bi_wr = 1'b1;
            state_in  = S_L1R;
         end
         S_L1R: begin
            cmd.rd_l1 = 1'b1;
            state_in  = S_FILL;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (sts.last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_blk = 1'b1;
                  state_in     = S_RD;
               end
            end
         end
         default: state_in = S_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLR;
      else       state_ff <= state_in;
   end
endmodule

// ----- rtl/tlc_dp.sv -----
// Tag, recency and age stores with lookup and update logic for the cache unit
`include "two_level_inclusive_cache_srrip_unit_defines.svh"
module tlc_dp #(
   parameter int L1_SETS    = tlc_pkg::DEF_L1_SETS,
   parameter int L1_WAYS    = tlc_pkg::DEF_L1_WAYS,
   parameter int L2_SETS    = tlc_pkg::DEF_L2_SETS,
   parameter int L2_WAYS    = tlc_pkg::DEF_L2_WAYS,
   parameter int ADDR_WIDTH = tlc_pkg::DEF_ADDR_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tlc_pkg::tlc_cmd_type         cmd,
   output tlc_pkg::tlc_sts_type         sts,
   input  logic [tlc_pkg::ADDR_W-1:0]   req_start_address,
   input  logic [tlc_pkg::SIZE_W-1:0]   req_access_size,
   output logic [tlc_pkg::BLK_W-1:0]    rsp_block_address,
   output logic                         rsp_l1_hit,
   output logic                         rsp_l2_hit,
   output logic                         rsp_last_block,
   output logic [tlc_pkg::CNT_W-1:0]    rsp_l1_miss_total,
   output logic [tlc_pkg::CNT_W-1:0]    rsp_l2_miss_total
);
   import tlc_pkg::*;

   localparam int EAW   = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
   localparam int BW    = EAW - BLOCK_SHIFT;
   localparam int L1IW  = $clog2(L1_SETS);
   localparam int L2IW  = $clog2(L2_SETS);
   localparam int L1TW  = BW - L1IW;
   localparam int L2TW  = BW - L2IW;
   localparam int L1WW  = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
   localparam int L2WW  = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
   localparam int NCLR  = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
   localparam int CW    = $clog2(NCLR);

   // set-wide memories
   logic [L1_WAYS-1:0][L1TW-1:0] l1_tag_mem  [L1_SETS];
   logic [L1_WAYS-1:0]           l1_val_mem  [L1_SETS];
   logic [L1_WAYS-1:0][L1WW-1:0] l1_rank_mem [L1_SETS];
   logic [L2_WAYS-1:0][L2TW-1:0] l2_tag_mem  [L2_SETS];
   logic [L2_WAYS-1:0]           l2_val_mem  [L2_SETS];
   logic [L2_WAYS-1:0][1:0]      l2_age_mem  [L2_SETS];

   logic [L1_WAYS-1:0][L1TW-1:0] l1_tag_rd_ff;
   logic [L1_WAYS-1:0]           l1_val_rd_ff;
   logic [L1_WAYS-1:0][L1WW-1:0] l1_rank_rd_ff;
   logic [L2_WAYS-1:0][L2TW-1:0] l2_tag_rd_ff;
   logic [L2_WAYS-1:0]           l2_val_rd_ff;
   logic [L2_WAYS-1:0][1:0]      l2_age_rd_ff;

   logic [BW-1:0]    blk_ff, sec_ff;
   logic             last_ff;
   logic [L1IW-1:0]  bi_set_ff, bi_set_in;
   logic [L1TW-1:0]  bi_tag_ff, bi_tag_in;
   logic             l1h_ff, l2h_ff;
   logic [CNT_W-1:0] l1_cnt_ff, l2_cnt_ff;
   logic [CW-1:0]    clr_cnt_ff;

   logic [L1IW-1:0] cur_l1_set;
   logic [L1TW-1:0] cur_l1_tag;
   logic [L2IW-1:0] cur_l2_set;
   logic [L2TW-1:0] cur_l2_tag;

   assign cur_l1_set = blk_ff[L1IW-1:0];
   assign cur_l1_tag = blk_ff[BW-1:L1IW];
   assign cur_l2_set = blk_ff[L2IW-1:0];
   assign cur_l2_tag = blk_ff[BW-1:L2IW];

   // request decode
   logic [EAW-1:0]    sa, ea;
   logic [SIZE_W-1:0] sz;
   always_comb begin
      sa = req_start_address[EAW-1:0];
      if (req_access_size == '0)                         sz = SIZE_W'(1);
      else if (req_access_size > SIZE_W'(BLOCK_BYTES))   sz = SIZE_W'(BLOCK_BYTES);
      else                                               sz = req_access_size;
      ea = sa + EAW'(sz) - EAW'(1);
   end

   // L1 lookup, touch, fill, back-invalidate
   logic                         l1_hit;
   logic [L1WW-1:0]              l1_hway;
   logic [L1_WAYS-1:0]           touch_val;
   logic [L1_WAYS-1:0][L1WW-1:0] touch_rank;
   logic [L1_WAYS-1:0][L1TW-1:0] fill_tag;
   logic [L1_WAYS-1:0]           fill_val;
   logic [L1_WAYS-1:0][L1WW-1:0] fill_rank;
   logic [L1_WAYS-1:0]           rem_val;
   logic [L1_WAYS-1:0][L1WW-1:0] rem_rank;

   always_comb begin
      logic [L1WW-1:0] r0;
      logic            any_inv;
      logic [L1WW-1:0] inv_way;
      logic [L1WW-1:0] old_way;
      logic [L1WW-1:0] slot;
      logic            bfound;
      logic [L1WW-1:0] bway;
      l1_hit  = 1'b0;
      l1_hway = '0;
      for (int w = L1_WAYS - 1; w >= 0; w--) begin
         if (l1_val_rd_ff[w] && l1_tag_rd_ff[w] == cur_l1_tag) begin
            l1_hit  = 1'b1;
            l1_hway = L1WW'(w);
         end
      end
      touch_val  = l1_val_rd_ff;
      touch_rank = l1_rank_rd_ff;
      r0 = l1_rank_rd_ff[l1_hway];
      for (int w = 0; w < L1_WAYS; w++)
         if (l1_val_rd_ff[w] && l1_rank_rd_ff[w] < r0) touch_rank[w] = l1_rank_rd_ff[w] + 1'b1;
      touch_rank[l1_hway] = '0;

      any_inv = 1'b0;
      inv_way = '0;
      for (int w = L1_WAYS - 1; w >= 0; w--) begin
         if (!l1_val_rd_ff[w]) begin
            any_inv = 1'b1;
            inv_way = L1WW'(w);
         end
      end
      old_way = '0;
      for (int w = 1; w < L1_WAYS; w++)
         if (l1_rank_rd_ff[w] > l1_rank_rd_ff[old_way]) old_way = L1WW'(w);
      fill_tag  = l1_tag_rd_ff;
      fill_val  = l1_val_rd_ff;
      fill_rank = l1_rank_rd_ff;
      if (any_inv) begin
         slot = inv_way;
      end else begin
         slot = old_way;
         r0   = l1_rank_rd_ff[old_way];
         fill_val[old_way] = 1'b0;
         for (int w = 0; w < L1_WAYS; w++)
            if (fill_val[w] && l1_rank_rd_ff[w] > r0) fill_rank[w] = l1_rank_rd_ff[w] - 1'b1;
      end
      for (int w = 0; w < L1_WAYS; w++)
         if (fill_val[w]) fill_rank[w] = fill_rank[w] + 1'b1;
      fill_tag[slot]  = cur_l1_tag;
      fill_val[slot]  = 1'b1;
      fill_rank[slot] = '0;

      bfound = 1'b0;
      bway   = '0;
      for (int w = L1_WAYS - 1; w >= 0; w--) begin
         if (l1_val_rd_ff[w] && l1_tag_rd_ff[w] == bi_tag_ff) begin
            bfound = 1'b1;
            bway   = L1WW'(w);
         end
      end
      rem_val  = l1_val_rd_ff;
      rem_rank = l1_rank_rd_ff;
      if (bfound) begin
         r0 = l1_rank_rd_ff[bway];
         rem_val[bway] = 1'b0;
         for (int w = 0; w < L1_WAYS; w++)
            if (rem_val[w] && l1_rank_rd_ff[w] > r0) rem_rank[w] = l1_rank_rd_ff[w] - 1'b1;
      end
   end

   // L2 lookup and SRRIP update
   logic                         l2_hit;
   logic                         l2_full;
   logic [L2_WAYS-1:0][L2TW-1:0] l2_wtag;
   logic [L2_WAYS-1:0]           l2_wval;
   logic [L2_WAYS-1:0][1:0]      l2_wage;

   always_comb begin
      logic [L2WW-1:0] hway;
      logic [L2WW-1:0] inv_way;
      logic [L2WW-1:0] slot;
      logic            found3;
      logic [1:0]      top;
      logic [1:0]      lift;
      logic [BW-1:0]   old_blk;
      l2_hit  = 1'b0;
      hway    = '0;
      l2_full = 1'b1;
      inv_way = '0;
      for (int w = L2_WAYS - 1; w >= 0; w--) begin
         if (l2_val_rd_ff[w] && l2_tag_rd_ff[w] == cur_l2_tag) begin
            l2_hit = 1'b1;
            hway   = L2WW'(w);
         end
         if (!l2_val_rd_ff[w]) begin
            l2_full = 1'b0;
            inv_way = L2WW'(w);
         end
      end
      top = '0;
      for (int w = 0; w < L2_WAYS; w++)
         if (l2_age_rd_ff[w] > top) top = l2_age_rd_ff[w];
      lift    = RRPV_MAX - top;
      l2_wtag = l2_tag_rd_ff;
      l2_wval = l2_val_rd_ff;
      l2_wage = l2_age_rd_ff;
      slot    = inv_way;
      found3  = 1'b0;
      if (l2_full) begin
         for (int w = 0; w < L2_WAYS; w++) begin
            l2_wage[w] = l2_age_rd_ff[w] + lift;
            if (!found3 && l2_wage[w] == RRPV_MAX) begin
               found3 = 1'b1;
               slot   = L2WW'(w);
            end
         end
      end
      old_blk   = {l2_tag_rd_ff[slot], cur_l2_set};
      bi_set_in = old_blk[L1IW-1:0];
      bi_tag_in = old_blk[BW-1:L1IW];
      if (l2_hit) begin
         l2_wage      = l2_age_rd_ff;
         l2_wage[hway] = RRPV_HIT;
      end else begin
         l2_wtag[slot] = cur_l2_tag;
         l2_wval[slot] = 1'b1;
         l2_wage[slot] = RRPV_FILL;
      end
   end

   logic need_bi;
   assign need_bi = !l1_hit && !l2_hit && l2_full;

   // memory ports
   logic                         l1_re, l1_we, l1_clr, l2_clr, l2_we;
   logic [L1IW-1:0]              l1_raddr, l1_waddr;
   logic [L1_WAYS-1:0][L1TW-1:0] l1_wtag;
   logic [L1_WAYS-1:0]           l1_wval;
   logic [L1_WAYS-1:0][L1WW-1:0] l1_wrank;

   always_comb begin
      l1_re    = cmd.rd_cur || cmd.bi_rd || cmd.rd_l1;
      l1_raddr = cmd.bi_rd ? bi_set_ff : cur_l1_set;
      l1_we    = (cmd.lookup && (l1_hit || !need_bi)) || cmd.bi_wr || cmd.fill;
      l1_waddr = cmd.bi_wr ? bi_set_ff : cur_l1_set;
      l1_clr   = cmd.clr && (32'(clr_cnt_ff) < L1_SETS);
      l2_clr   = cmd.clr && (32'(clr_cnt_ff) < L2_SETS);
      l2_we    = cmd.lookup && !l1_hit;
      l1_wtag  = fill_tag;
      l1_wval  = fill_val;
      l1_wrank = fill_rank;
      if (cmd.bi_wr) begin
         l1_wtag  = l1_tag_rd_ff;
         l1_wval  = rem_val;
         l1_wrank = rem_rank;
      end else if (cmd.lookup && l1_hit) begin
         l1_wtag  = l1_tag_rd_ff;
         l1_wval  = touch_val;
         l1_wrank = touch_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (l1_re) begin
         l1_tag_rd_ff  <= l1_tag_mem[l1_raddr];
         l1_val_rd_ff  <= l1_val_mem[l1_raddr];
         l1_rank_rd_ff <= l1_rank_mem[l1_raddr];
      end
      if (l1_we) begin
         l1_tag_mem[l1_waddr]  <= l1_wtag;
         l1_rank_mem[l1_waddr] <= l1_wrank;
      end
      if (l1_clr)     l1_val_mem[clr_cnt_ff[L1IW-1:0]] <= '0;
      else if (l1_we) l1_val_mem[l1_waddr] <= l1_wval;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_cur) begin
         l2_tag_rd_ff <= l2_tag_mem[cur_l2_set];
         l2_val_rd_ff <= l2_val_mem[cur_l2_set];
         l2_age_rd_ff <= l2_age_mem[cur_l2_set];
      end
      if (l2_we) begin
         l2_tag_mem[cur_l2_set] <= l2_wtag;
         l2_age_mem[cur_l2_set] <= l2_wage;
      end
      if (l2_clr)     l2_val_mem[clr_cnt_ff[L2IW-1:0]] <= '0;
      else if (l2_we) l2_val_mem[cur_l2_set] <= l2_wval;
   end

   // block sequencing, victim capture, result flags
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blk_ff  <= sa[EAW-1:BLOCK_SHIFT];
         sec_ff  <= ea[EAW-1:BLOCK_SHIFT];
         last_ff <= (sa[EAW-1:BLOCK_SHIFT] == ea[EAW-1:BLOCK_SHIFT]);
      end else if (cmd.next_blk) begin
         blk_ff  <= sec_ff;
         last_ff <= 1'b1;
      end
      if (cmd.lookup) begin
         bi_set_ff <= bi_set_in;
         bi_tag_ff <= bi_tag_in;
         l1h_ff    <= l1_hit;
         l2h_ff    <= !l1_hit && l2_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_cnt_ff  <= '0;
         l2_cnt_ff  <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.lookup && !l1_hit) l1_cnt_ff <= l1_cnt_ff + 1'b1;
         if (cmd.lookup && !l1_hit && !l2_hit) l2_cnt_ff <= l2_cnt_ff + 1'b1;
         if (cmd.clr) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign sts.clr_done = (32'(clr_cnt_ff) == NCLR - 1);
   assign sts.need_bi  = need_bi;
   assign sts.last     = last_ff;

   assign rsp_block_address = BLK_W'(blk_ff);
   assign rsp_l1_hit        = l1h_ff;
   assign rsp_l2_hit        = l2h_ff;
   assign rsp_last_block    = last_ff;
   assign rsp_l1_miss_total = l1_cnt_ff;
   assign rsp_l2_miss_total = l2_cnt_ff;

   `TLC_ASSERT_NEVER(a_hit_flags_excl, clock, reset, l1h_ff === 1'b1 && l2h_ff === 1'b1)
   `TLC_ASSERT_IMPL(a_l1_cnt_hold, clock, reset, !cmd.lookup, $stable(l1_cnt_ff))
   `TLC_ASSERT_IMPL(a_l2_cnt_hold, clock, reset, cmd.lookup && l1_hit, $stable(l2_cnt_ff))
endmodule

// ----- sim/tb_two_level_inclusive_cache_srrip_unit.sv -----
// Self-checking testbench for the two-level inclusive tag cache with LRU L1 and SRRIP L2
`timescale 1ns / 1ps
module tb_two_level_inclusive_cache_srrip_unit;
   import tlc_pkg::*;

   localparam int L1S = 128, L1W = 8, L2S = 1024, L2W = 16;
   localparam int LIMIT = 1000000;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
      logic              hold;
   } access_type;

   typedef struct packed {
      logic [BLK_W-1:0] blk;
      logic             h1;
      logic             h2;
      logic             last;
      logic [CNT_W-1:0] m1;
      logic [CNT_W-1:0] m2;
   } block_result_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 1;
   logic [ADDR_W-1:0] req_start_address = '0;
   logic [SIZE_W-1:0] req_access_size = 1;
   logic [BLK_W-1:0] rsp_block_address;
   logic rsp_l1_hit, rsp_l2_hit, rsp_last_block;
   logic [CNT_W-1:0] rsp_l1_miss_total, rsp_l2_miss_total;

   two_level_inclusive_cache_srrip_unit dut (.*);

   access_type       pending_accesses[$];
   block_result_type expected_blocks[$];

   logic [41:0] l1_tag[L1S*L1W];
   bit          l1_vld[L1S*L1W];
   int          l1_rank[L1S*L1W];
   logic [41:0] l2_tag[L2S*L2W];
   bit          l2_vld[L2S*L2W];
   int          l2_age[L2S*L2W];
   logic [CNT_W-1:0] l1_misses = 0, l2_misses = 0;

   int  errors = 0;
   int  cycles = 0;
   bit  feeding_done = 0;
   int  gap = 0, rgap = 0;

   function automatic int l1_lookup(int b, logic [41:0] t);
      for (int w = 0; w < L1W; w++)
         if (l1_vld[b+w] && l1_tag[b+w] == t) return w;
      return -1;
   endfunction

   function automatic void l1_drop(int b, int way);
      int r;
      r = l1_rank[b+way];
      l1_vld[b+way] = 0;
      for (int w = 0; w < L1W; w++)
         if (l1_vld[b+w] && l1_rank[b+w] > r) l1_rank[b+w]--;
   endfunction

   function automatic void predict_block(logic [41:0] blk, bit last);
      int b1, b2, way, slot, top, hw, vb;
      logic [41:0] t1, t2, victim;
      block_result_type r;
      b1 = int'(blk % L1S) * L1W;
      t1 = blk / L1S;
      r = '0;
      way = l1_lookup(b1, t1);
      if (way >= 0) begin
         for (int w = 0; w < L1W; w++)
            if (l1_vld[b1+w] && l1_rank[b1+w] < l1_rank[b1+way]) l1_rank[b1+w]++;
         l1_rank[b1+way] = 0;
         r.h1 = 1'b1;
      end else begin
         l1_misses++;
         b2 = int'(blk % L2S) * L2W;
         t2 = blk / L2S;
         hw = -1;
         for (int w = 0; w < L2W && hw < 0; w++)
            if (l2_vld[b2+w] && l2_tag[b2+w] == t2) hw = w;
         if (hw >= 0) begin
            l2_age[b2+hw] = 0;
            r.h2 = 1'b1;
         end else begin
            l2_misses++;
            slot = -1;
            for (int w = 0; w < L2W && slot < 0; w++)
               if (!l2_vld[b2+w]) slot = w;
            if (slot < 0) begin
               top = 0;
               for (int w = 0; w < L2W; w++) if (l2_age[b2+w] > top) top = l2_age[b2+w];
               for (int w = 0; w < L2W; w++) begin
                  l2_age[b2+w] += 3 - top;
                  if (slot < 0 && l2_age[b2+w] == 3) slot = w;
               end
               victim = l2_tag[b2+slot] * L2S + blk % L2S;
               vb = int'(victim % L1S) * L1W;
               hw = l1_lookup(vb, victim / L1S);
               if (hw >= 0) l1_drop(vb, hw);
            end
            l2_tag[b2+slot] = t2;
            l2_vld[b2+slot] = 1;
            l2_age[b2+slot] = 2;
         end
         slot = -1;
         for (int w = 0; w < L1W && slot < 0; w++)
            if (!l1_vld[b1+w]) slot = w;
         if (slot < 0) begin
            slot = 0;
            for (int w = 1; w < L1W; w++) if (l1_rank[b1+w] > l1_rank[b1+slot]) slot = w;
            l1_drop(b1, slot);
         end
         for (int w = 0; w < L1W; w++) if (l1_vld[b1+w]) l1_rank[b1+w]++;
         l1_tag[b1+slot] = t1;
         l1_vld[b1+slot] = 1;
         l1_rank[b1+slot] = 0;
      end
      r.blk = blk;
      r.last = last;
      r.m1 = l1_misses;
      r.m2 = l2_misses;
      expected_blocks.insert(expected_blocks.size(), r);
   endfunction

   function automatic void predict_access(logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
      logic [ADDR_W-1:0] e;
      int n;
      n = (s == 0) ? 1 : (s > 64 ? 64 : s);
      e = a + ADDR_W'(n) - ADDR_W'(1);
      if (e[ADDR_W-1:6] == a[ADDR_W-1:6]) predict_block(a[ADDR_W-1:6], 1);
      else begin
         predict_block(a[ADDR_W-1:6], 0);
         predict_block(e[ADDR_W-1:6], 1);
      end
   endfunction

   function automatic void queue_access(logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s,
                                        bit hold = 0);
      access_type x;
      x.addr = a; x.size = s; x.hold = hold;
      pending_accesses.insert(pending_accesses.size(), x);
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      logic [ADDR_W-1:0] hot[16];
      logic [ADDR_W-1:0] a;
      repeat (6) @(posedge clock);
      reset <= 0;
      queue_access('0, 1);
      queue_access('0, 64);
      queue_access(48'h3f, 2);
      queue_access('1, 1);
      queue_access('1, 64);
      queue_access(48'hffff_ffff_ffc0, 64);
      queue_access(48'h1234_5678_9abc, 0);
      queue_access(48'h1234_5678_9a80, 127);
      queue_access(48'h1234_5678_9a80, 65);
      queue_access(48'haaaa_aaaa_aaaa, 100);
      queue_access(48'h5555_5555_5555, 7, 1);
      // fill one L2 set past its ways, mixing L1 hits and back-invalidates
      for (int i = 0; i < 20; i++) queue_access(48'(i) << 16, SIZE_W'($urandom_range(1, 64)));
      queue_access('0, 1);
      for (int i = 0; i < 16; i++) hot[i] = ADDR_W'({$urandom, $urandom}) & 48'h0000_00ff_ffc0;
      for (int i = 0; i < 1250; i++) begin
         case ($urandom_range(0, 9))
            0, 1: a = ADDR_W'({$urandom, $urandom});
            2, 3, 4: a = hot[$urandom_range(0, 15)] + ADDR_W'($urandom_range(0, 127));
            5, 6: a = (48'($urandom_range(0, 40)) << 16) | 48'($urandom_range(0, 3) << 6);
            7: a = ADDR_W'({$urandom, $urandom}) | 48'hffff_ffff_ff00;
            default: a = 48'($urandom_range(0, 8191));
         endcase
         queue_access(a, SIZE_W'($urandom_range(0, 127)), i == 600);
      end
      feeding_done = 1;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_access(req_start_address, req_access_size);
            gap = pick_gap();
         end
         if (req_valid && req_stall) begin
         end else if (gap > 0) begin
            gap--;
            req_valid <= 0;
         end else if (pending_accesses.size() > 0 &&
                      !(pending_accesses[0].hold && expected_blocks.size() > 0)) begin
            req_valid <= 1;
            req_start_address <= pending_accesses[0].addr;
            req_access_size <= pending_accesses[0].size;
            void'(pending_accesses.pop_front());
         end else req_valid <= 0;
      end
   end

   always @(posedge clock) begin
      block_result_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               errors++;
               $display("%0t unexpected item blk=%h", $time, rsp_block_address);
            end else begin
               e = expected_blocks.pop_front();
               if (e != {rsp_block_address, rsp_l1_hit, rsp_l2_hit, rsp_last_block,
                         rsp_l1_miss_total, rsp_l2_miss_total}) begin
                  errors++;
                  $display("%0t mismatch exp blk=%h h1=%b h2=%b last=%b m1=%0d m2=%0d",
                           $time, e.blk, e.h1, e.h2, e.last, e.m1, e.m2);
                  $display("%0t          got blk=%h h1=%b h2=%b last=%b m1=%0d m2=%0d",
                           $time, rsp_block_address, rsp_l1_hit, rsp_l2_hit,
                           rsp_last_block, rsp_l1_miss_total, rsp_l2_miss_total);
               end
            end
         end
         if (rgap > 0) begin
            rgap--;
            rsp_stall <= 1;
         end else begin
            rgap = pick_gap();
            rsp_stall <= 0;
         end
      end
   end

   initial begin
      for (int i = 0; i < L1S*L1W; i++) l1_vld[i] = 0;
      for (int i = 0; i < L2S*L2W; i++) l2_vld[i] = 0;
      wait (feeding_done);
      while (cycles < LIMIT && (pending_accesses.size() > 0 || req_valid ||
                                expected_blocks.size() > 0))
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (cycles >= LIMIT) begin
         $display("tb_two_level_inclusive_cache_srrip_unit: FAIL");
      end else if (errors == 0 && expected_blocks.size() == 0) begin
         $display("tb_two_level_inclusive_cache_srrip_unit: PASS");
      end else begin
         $display("tb_two_level_inclusive_cache_srrip_unit: FAIL");
      end
      $finish;
   end
endmodule
